// File: hdl/rmi_pkg.sv
// rmi_pkg: shared types and constants for the arm motion interpolator
// holds command and status codes, controller states and the control structs
// no dependencies
`timescale 1ns / 1ps

package rmi_pkg;

	localparam int LINK_W    = 12;
	localparam int CFG_IDX_W = 2;
	localparam int STEP_W    = 4;
	localparam int REM_W     = STEP_W + 1;

	localparam logic [LINK_W-1:0] L1_RST  = 12'd200;
	localparam logic [LINK_W-1:0] L2_RST  = 12'd150;
	localparam logic [LINK_W-1:0] CLR_RST = 12'd50;

	localparam logic [CFG_IDX_W-1:0] CFG_L1    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_L2    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLR   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	localparam logic [STEP_W-1:0] STEP_BASE = 4'd11;
	localparam logic [STEP_W-1:0] STEP_MIN  = 4'd3;
	localparam logic [STEP_W-1:0] STEP_RST  = 4'd3;
	localparam logic [STEP_W-1:0] STEP_ONE  = 4'd1;
	localparam int STEP_CAP = 11;

	localparam int SPEED_MAX   = 100;
	localparam int SPEED_RECIP = 205;
	localparam int SPEED_SHIFT = 11;

	typedef enum logic [2:0] {
		OP_HOME,
		OP_MOVE,
		OP_JOINT,
		OP_APPR,
		OP_RETRACT,
		OP_SETSPD,
		OP_OPEN,
		OP_SHUT
	} op_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_REACH,
		ST_NEGZ,
		ST_SPEED
	} status_t;

	typedef enum logic [1:0] {
		SEG_LINEAR,
		SEG_LIFT,
		SEG_TRAVERSE,
		SEG_DESCENT
	} seg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_SUM,
		S_CMP,
		S_LOAD,
		S_DIV,
		S_POINT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic       capture;
		logic       mul;
		logic       sum;
		logic       cmp;
		logic       seg_load;
		logic       point;
		logic       emit;
		logic       last_seg;
		logic [1:0] seg_idx;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic err;
		logic div_done;
		logic pt_last;
		logic out_free;
	} dp_stat_t;

endpackage

// File: hdl/rmi_div.sv
// rmi_div: three-lane bit-serial restoring divider sharing one small divisor
// one quotient bit per cycle per lane; uses rmi_pkg
`timescale 1ns / 1ps

module rmi_div #(
	parameter int NUM_W = 15
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [2:0][NUM_W-1:0]                num,
	input  logic [rmi_pkg::STEP_W-1:0]           den,
	output logic [2:0][NUM_W-1:0]                quo,
	output logic [2:0][rmi_pkg::STEP_W-1:0]      rem,
	output logic                                 busy
);

	localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

	logic                                busy_q;
	logic [CNT_W-1:0]                    cnt_q;
	logic [2:0][NUM_W-1:0]               quo_q;
	logic [2:0][rmi_pkg::STEP_W-1:0]     rem_q;
	logic [rmi_pkg::STEP_W-1:0]          den_q;
	logic [2:0][rmi_pkg::REM_W-1:0]      trial;
	logic [2:0][rmi_pkg::REM_W-1:0]      diff;
	logic [2:0]                          ge;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			trial[k] = {rem_q[k], quo_q[k][NUM_W-1]};
			ge[k]    = trial[k] >= {1'b0, den_q};
			diff[k]  = trial[k] - {1'b0, den_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			for (int k = 0; k < 3; k++) begin
				quo_q[k] <= {quo_q[k][NUM_W-2:0], ge[k]};
				rem_q[k] <= ge[k] ? diff[k][rmi_pkg::STEP_W-1:0]
					: trial[k][rmi_pkg::STEP_W-1:0];
			end
		end
	end

	assign quo  = quo_q;
	assign rem  = rem_q;
	assign busy = busy_q;

endmodule

// File: hdl/rmi_dp.sv
// rmi_dp: datapath of the arm motion interpolator
// holds pose, settings, target check, segment stepping and result register
// uses rmi_pkg and rmi_div
`timescale 1ns / 1ps

module rmi_dp #(
	parameter int COORD_WIDTH = 14,
	parameter int MAX_STEPS   = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rmi_pkg::dp_cmd_t                    cmd,
	output rmi_pkg::dp_stat_t                   stat,
	input  logic [2:0]                          opcode,
	input  logic signed [COORD_WIDTH-1:0]       target_x,
	input  logic signed [COORD_WIDTH-1:0]       target_y,
	input  logic signed [COORD_WIDTH-1:0]       target_z,
	input  logic signed [COORD_WIDTH-1:0]       amount,
	input  logic                                cfg_we,
	input  logic [rmi_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rmi_pkg::LINK_W-1:0]          cfg_data,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic signed [COORD_WIDTH-1:0]       out_x,
	output logic signed [COORD_WIDTH-1:0]       out_y,
	output logic signed [COORD_WIDTH-1:0]       out_z,
	output logic                                gripper_is_open,
	output logic [1:0]                          segment,
	output logic [1:0]                          status,
	output logic                                last
);

	localparam int CW   = COORD_WIDTH;
	localparam int DW   = CW + 1;
	localparam int ZW   = CW + 2;
	localparam int SQW  = 2 * CW;
	localparam int LSW  = rmi_pkg::LINK_W + 1;
	localparam int D2W  = (SQW > 2 * LSW) ? SQW : 2 * LSW;
	localparam int SW   = rmi_pkg::STEP_W;
	localparam int MAXS = (MAX_STEPS > rmi_pkg::STEP_CAP) ? rmi_pkg::STEP_CAP : MAX_STEPS;
	localparam logic [SW-1:0] MAXS_V = SW'(MAXS);
	localparam logic signed [ZW-1:0] ZMAX = ZW'((1 << (CW - 1)) - 1);
	localparam logic signed [ZW-1:0] ZMIN = ~ZMAX;
	localparam logic signed [CW-1:0] SPD_MAX_V = CW'(rmi_pkg::SPEED_MAX);

	function automatic logic signed [CW-1:0] sat_z(input logic signed [ZW-1:0] v);
		logic signed [ZW-1:0] r;
		r = v;
		if (v > ZMAX) r = ZMAX;
		if (v < ZMIN) r = ZMIN;
		sat_z = CW'(r);
	endfunction

	// settings and pose
	logic [rmi_pkg::LINK_W-1:0]   l1_q, l2_q, clr_q;
	logic signed [CW-1:0]         cur_q [3];
	logic [SW-1:0]                steps_q;
	logic                         grip_q;

	// request
	rmi_pkg::op_t                 op_q;
	logic signed [CW-1:0]         tx_q, ty_q, tz_q, amt_q;

	// target check
	logic signed [SQW-1:0]        xx_c, yy_c;
	logic [SQW-1:0]               xx_q, yy_q;
	logic [LSW-1:0]               lsum;
	logic [rmi_pkg::LINK_W-1:0]   ldif;
	logic [2*LSW-1:0]             lsum2_q;
	logic [2*rmi_pkg::LINK_W-1:0] ldif2_q;
	logic [D2W-1:0]               d2_q;
	logic                         reach_bad;
	rmi_pkg::status_t             status_c, status_q;
	logic signed [ZW-1:0]         czx, tzx, clrx, amtx, hi_a, joint_z, up_z, appr_z, dep_z;
	logic signed [CW-1:0]         aux_c, aux_z_q;

	// segment
	logic signed [CW-1:0]         tgt [3];
	logic [SW-1:0]                steps_c;
	rmi_pkg::seg_t                code_c, seg_code_q;
	logic signed [DW-1:0]         delta [3];
	logic [2:0][DW-1:0]           div_num, div_quo;
	logic [2:0][SW-1:0]           div_rem;
	logic                         div_busy;
	logic signed [CW-1:0]         seg_start_q [3];
	logic [2:0]                   seg_neg_q;
	logic [SW-1:0]                seg_steps_q;
	logic [DW-1:0]                q_acc_q [3];
	logic [SW-1:0]                r_acc_q [3];
	logic [SW-1:0]                idx_q;
	logic [rmi_pkg::REM_W-1:0]    r_sum [3];
	logic [2:0]                   wrap;
	logic signed [ZW-1:0]         qx [3];
	logic signed [ZW-1:0]         coord_w [3];
	logic signed [CW-1:0]         coord [3];

	// speed to step count
	logic [14:0]                  spd_prod;
	logic [SW-1:0]                tenth, raw_steps, new_steps;

	// result register
	logic                         out_valid_q;
	logic signed [CW-1:0]         out_x_q, out_y_q, out_z_q;
	logic                         out_grip_q, out_last_q;
	rmi_pkg::seg_t                out_seg_q;
	rmi_pkg::status_t             out_status_q;
	logic                         pt_last;

	assign xx_c = tx_q * tx_q;
	assign yy_c = ty_q * ty_q;
	assign lsum = LSW'(l1_q) + LSW'(l2_q);
	assign ldif = (l1_q >= l2_q) ? (l1_q - l2_q) : (l2_q - l1_q);
	assign reach_bad = (d2_q < D2W'(ldif2_q)) || (d2_q > D2W'(lsum2_q));

	assign czx     = ZW'(cur_q[2]);
	assign tzx     = ZW'(tz_q);
	assign clrx    = signed'(ZW'(clr_q));
	assign amtx    = ZW'(amt_q);
	assign hi_a    = (czx > tzx) ? czx : tzx;
	assign joint_z = hi_a + clrx;
	assign up_z    = tzx + clrx;
	assign appr_z  = (czx > up_z) ? czx : up_z;
	assign dep_z   = czx + amtx;

	always_comb begin
		status_c = rmi_pkg::ST_OK;
		aux_c    = cur_q[2];
		case (op_q)
			rmi_pkg::OP_MOVE, rmi_pkg::OP_JOINT, rmi_pkg::OP_APPR: begin
				if (reach_bad) begin
					status_c = rmi_pkg::ST_REACH;
				end else if (tz_q < 0) begin
					status_c = rmi_pkg::ST_NEGZ;
				end
			end
			rmi_pkg::OP_SETSPD: begin
				if ((amt_q < 0) || (amt_q > SPD_MAX_V)) begin
					status_c = rmi_pkg::ST_SPEED;
				end
			end
			default: begin
			end
		endcase
		case (op_q)
			rmi_pkg::OP_JOINT:   aux_c = sat_z(joint_z);
			rmi_pkg::OP_APPR:    aux_c = sat_z(appr_z);
			rmi_pkg::OP_RETRACT: aux_c = sat_z(dep_z);
			default: begin
			end
		endcase
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			tgt[k] = cur_q[k];
		end
		steps_c = rmi_pkg::STEP_ONE;
		code_c  = rmi_pkg::SEG_LINEAR;
		if (status_q == rmi_pkg::ST_OK) begin
			case (op_q)
				rmi_pkg::OP_HOME: begin
					for (int k = 0; k < 3; k++) begin
						tgt[k] = '0;
					end
				end
				rmi_pkg::OP_MOVE: begin
					tgt[0]  = tx_q;
					tgt[1]  = ty_q;
					tgt[2]  = tz_q;
					steps_c = steps_q;
				end
				rmi_pkg::OP_JOINT: begin
					code_c = rmi_pkg::seg_t'(cmd.seg_idx + 2'd1);
					case (cmd.seg_idx)
						2'd0: begin
							tgt[2]  = aux_z_q;
							steps_c = steps_q >> 1;
						end
						2'd1: begin
							tgt[0]  = tx_q;
							tgt[1]  = ty_q;
							tgt[2]  = aux_z_q;
							steps_c = steps_q;
						end
						default: begin
							tgt[0]  = tx_q;
							tgt[1]  = ty_q;
							tgt[2]  = tz_q;
							steps_c = steps_q >> 1;
						end
					endcase
				end
				rmi_pkg::OP_APPR: begin
					tgt[0] = tx_q;
					tgt[1] = ty_q;
					tgt[2] = (cmd.seg_idx == 2'd0) ? aux_z_q : tz_q;
				end
				rmi_pkg::OP_RETRACT: begin
					tgt[2] = aux_z_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			delta[k]   = DW'(tgt[k]) - DW'(cur_q[k]);
			div_num[k] = delta[k][DW-1] ? DW'(-delta[k]) : DW'(delta[k]);
		end
	end

	rmi_div #(
		.NUM_W(DW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.seg_load),
		.num   (div_num),
		.den   (steps_c),
		.quo   (div_quo),
		.rem   (div_rem),
		.busy  (div_busy)
	);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			r_sum[k]   = rmi_pkg::REM_W'(r_acc_q[k]) + rmi_pkg::REM_W'(div_rem[k]);
			wrap[k]    = r_sum[k] >= rmi_pkg::REM_W'(seg_steps_q);
			qx[k]      = signed'(ZW'(q_acc_q[k]));
			coord_w[k] = ZW'(seg_start_q[k]) + (seg_neg_q[k] ? -qx[k] : qx[k]);
			coord[k]   = CW'(coord_w[k]);
		end
	end

	assign spd_prod  = 15'(amt_q[6:0]) * 15'(rmi_pkg::SPEED_RECIP);
	assign tenth     = SW'(spd_prod >> rmi_pkg::SPEED_SHIFT);
	assign raw_steps = rmi_pkg::STEP_BASE - tenth;
	always_comb begin
		new_steps = raw_steps;
		if (raw_steps < rmi_pkg::STEP_MIN) new_steps = rmi_pkg::STEP_MIN;
		if (raw_steps > MAXS_V) new_steps = MAXS_V;
	end

	assign pt_last = (idx_q == seg_steps_q);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_q        <= rmi_pkg::L1_RST;
			l2_q        <= rmi_pkg::L2_RST;
			clr_q       <= rmi_pkg::CLR_RST;
			for (int k = 0; k < 3; k++) begin
				cur_q[k] <= '0;
			end
			steps_q     <= rmi_pkg::STEP_RST;
			grip_q      <= 1'b1;
			idx_q       <= '0;
			seg_steps_q <= rmi_pkg::STEP_ONE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rmi_pkg::CFG_L1:  l1_q  <= cfg_data;
					rmi_pkg::CFG_L2:  l2_q  <= cfg_data;
					rmi_pkg::CFG_CLR: clr_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.seg_load) begin
				idx_q       <= '0;
				seg_steps_q <= steps_c;
				if ((cmd.seg_idx == 2'd0) && (status_q == rmi_pkg::ST_OK)) begin
					case (op_q)
						rmi_pkg::OP_SETSPD: steps_q <= new_steps;
						rmi_pkg::OP_OPEN:   grip_q  <= 1'b1;
						rmi_pkg::OP_SHUT:   grip_q  <= 1'b0;
						default: begin
						end
					endcase
				end
			end
			if (cmd.point) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.emit) begin
				for (int k = 0; k < 3; k++) begin
					cur_q[k] <= coord[k];
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= rmi_pkg::op_t'(opcode);
			tx_q  <= target_x;
			ty_q  <= target_y;
			tz_q  <= target_z;
			amt_q <= amount;
		end
		if (cmd.mul) begin
			xx_q    <= xx_c;
			yy_q    <= yy_c;
			lsum2_q <= lsum * lsum;
			ldif2_q <= ldif * ldif;
		end
		if (cmd.sum) begin
			d2_q <= D2W'(xx_q) + D2W'(yy_q);
		end
		if (cmd.cmp) begin
			status_q <= status_c;
			aux_z_q  <= aux_c;
		end
		if (cmd.seg_load) begin
			for (int k = 0; k < 3; k++) begin
				seg_start_q[k] <= cur_q[k];
				seg_neg_q[k]   <= delta[k][DW-1];
				q_acc_q[k]     <= '0;
				r_acc_q[k]     <= '0;
			end
			seg_code_q <= code_c;
		end
		if (cmd.point) begin
			for (int k = 0; k < 3; k++) begin
				r_acc_q[k] <= wrap[k] ? SW'(r_sum[k] - rmi_pkg::REM_W'(seg_steps_q))
					: SW'(r_sum[k]);
				q_acc_q[k] <= q_acc_q[k] + div_quo[k] + DW'(wrap[k]);
			end
		end
		if (cmd.emit) begin
			out_x_q      <= coord[0];
			out_y_q      <= coord[1];
			out_z_q      <= coord[2];
			out_grip_q   <= grip_q;
			out_seg_q    <= seg_code_q;
			out_status_q <= status_q;
			out_last_q   <= cmd.last_seg && pt_last;
		end
	end

	assign stat.op       = op_q;
	assign stat.err      = (status_q != rmi_pkg::ST_OK);
	assign stat.div_done = !div_busy;
	assign stat.pt_last  = pt_last;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid       = out_valid_q;
	assign out_x           = out_x_q;
	assign out_y           = out_y_q;
	assign out_z           = out_z_q;
	assign gripper_is_open = out_grip_q;
	assign segment         = out_seg_q;
	assign status          = out_status_q;
	assign last            = out_last_q;

	a_rem_below_steps: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.point |=> ((r_acc_q[0] < seg_steps_q) && (r_acc_q[1] < seg_steps_q)
			&& (r_acc_q[2] < seg_steps_q)))
		else $error("remainder not below step count");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= seg_steps_q)
		else $error("point index past step count");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && stat.err) |-> (cmd.last_seg && pt_last))
		else $error("error request gave more than one result");

endmodule

// File: hdl/rmi_ctrl.sv
// rmi_ctrl: controller state machine of the arm motion interpolator
// sequences check, segment load, division and point output; uses rmi_pkg
`timescale 1ns / 1ps

module rmi_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rmi_pkg::dp_stat_t stat,
	output rmi_pkg::dp_cmd_t  cmd
);

	rmi_pkg::state_t state_q, state_d;
	logic [1:0]      seg_idx_q;
	logic            last_seg;

	always_comb begin
		last_seg = 1'b1;
		if (!stat.err) begin
			case (stat.op)
				rmi_pkg::OP_JOINT: last_seg = (seg_idx_q == 2'd2);
				rmi_pkg::OP_APPR:  last_seg = (seg_idx_q == 2'd1);
				default:           last_seg = 1'b1;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rmi_pkg::S_IDLE:  if (in_valid) state_d = rmi_pkg::S_MUL;
			rmi_pkg::S_MUL:   state_d = rmi_pkg::S_SUM;
			rmi_pkg::S_SUM:   state_d = rmi_pkg::S_CMP;
			rmi_pkg::S_CMP:   state_d = rmi_pkg::S_LOAD;
			rmi_pkg::S_LOAD:  state_d = rmi_pkg::S_DIV;
			rmi_pkg::S_DIV:   if (stat.div_done) state_d = rmi_pkg::S_POINT;
			rmi_pkg::S_POINT: state_d = rmi_pkg::S_OUT;
			rmi_pkg::S_OUT: begin
				if (stat.out_free) begin
					if (!stat.pt_last) begin
						state_d = rmi_pkg::S_POINT;
					end else if (last_seg) begin
						state_d = rmi_pkg::S_IDLE;
					end else begin
						state_d = rmi_pkg::S_LOAD;
					end
				end
			end
			default: state_d = rmi_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == rmi_pkg::S_IDLE);
		cmd.capture  = (state_q == rmi_pkg::S_IDLE) && in_valid;
		cmd.mul      = (state_q == rmi_pkg::S_MUL);
		cmd.sum      = (state_q == rmi_pkg::S_SUM);
		cmd.cmp      = (state_q == rmi_pkg::S_CMP);
		cmd.seg_load = (state_q == rmi_pkg::S_LOAD);
		cmd.point    = (state_q == rmi_pkg::S_POINT);
		cmd.emit     = (state_q == rmi_pkg::S_OUT) && stat.out_free;
		cmd.last_seg = last_seg;
		cmd.seg_idx  = seg_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rmi_pkg::S_IDLE;
			seg_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) begin
				seg_idx_q <= '0;
			end else if (cmd.emit && stat.pt_last && !last_seg) begin
				seg_idx_q <= seg_idx_q + 2'd1;
			end
		end
	end

	a_load_then_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rmi_pkg::S_LOAD) |=> (state_q == rmi_pkg::S_DIV))
		else $error("segment load not followed by division");

	a_seg_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rmi_pkg::S_MUL) |-> (seg_idx_q == 2'd0))
		else $error("segment index not cleared for new request");

	a_multi_seg_op: assert property (@(posedge clk) disable iff (!arst_n)
		(seg_idx_q != 2'd0) && (state_q != rmi_pkg::S_IDLE) |->
			((stat.op == rmi_pkg::OP_JOINT) || (stat.op == rmi_pkg::OP_APPR)))
		else $error("second segment on single segment request");

	a_point_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rmi_pkg::S_POINT) |->
			(($past(state_q) == rmi_pkg::S_DIV) || ($past(state_q) == rmi_pkg::S_OUT)))
		else $error("point step entered from wrong state");

endmodule

// File: hdl/robot_move_interpolator_top.sv
// robot_move_interpolator_top: arm motion command interpolator, top level
// joins rmi_ctrl and rmi_dp; uses rmi_pkg
//
// channel  | handshake              | payload
// ---------+------------------------+------------------------------------------
// request  | in_valid / in_ready    | opcode, target_x, target_y, target_z, amount
// result   | out_valid / out_ready  | out_x, out_y, out_z, gripper_is_open,
//          |                        | segment, status, last
// config   | cfg_we                 | cfg_index, cfg_data
//
// a request is accepted, then passes the reach check in the multiply, sum and compare states;
// then per segment a load state and the shared serial divider, and per point a point and an output state.
// a joint move has three segments and up to 20 points in all.
// the next request is taken once the last result sits in the output register.
// a stalled result holds the sequencer in its output state; no clearing pass after reset.
`timescale 1ns / 1ps

module robot_move_interpolator_top #(
	parameter int COORD_WIDTH = 14,
	parameter int MAX_STEPS   = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [2:0]                         opcode,
	input  logic signed [COORD_WIDTH-1:0]      target_x,
	input  logic signed [COORD_WIDTH-1:0]      target_y,
	input  logic signed [COORD_WIDTH-1:0]      target_z,
	input  logic signed [COORD_WIDTH-1:0]      amount,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [COORD_WIDTH-1:0]      out_x,
	output logic signed [COORD_WIDTH-1:0]      out_y,
	output logic signed [COORD_WIDTH-1:0]      out_z,
	output logic                               gripper_is_open,
	output logic [1:0]                         segment,
	output logic [1:0]                         status,
	output logic                               last,
	input  logic                               cfg_we,
	input  logic [rmi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rmi_pkg::LINK_W-1:0]         cfg_data
);

	rmi_pkg::dp_cmd_t  cmd;
	rmi_pkg::dp_stat_t stat;

	rmi_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	rmi_dp #(
		.COORD_WIDTH(COORD_WIDTH),
		.MAX_STEPS  (MAX_STEPS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.opcode         (opcode),
		.target_x       (target_x),
		.target_y       (target_y),
		.target_z       (target_z),
		.amount         (amount),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.out_x          (out_x),
		.out_y          (out_y),
		.out_z          (out_z),
		.gripper_is_open(gripper_is_open),
		.segment        (segment),
		.status         (status),
		.last           (last)
	);

endmodule
